>>> rtl/gda_pkg.sv
// ----------------------------------------------------------------------------
// GPS distance accumulator package
// Shared widths, register indexes, fixed-point constants, sequencer codes and
// elaboration-time table functions for the great-circle odometer.
// ----------------------------------------------------------------------------
package gda_pkg;

  // Default CORDIC iteration count.
  localparam int CORDIC_ITER_DEF = 32;

  // Field widths.
  localparam int LAT_W      = 31;
  localparam int LON_W      = 32;
  localparam int SEG_W      = 32;
  localparam int TOT_W      = 48;
  localparam int THR_W      = 27;
  localparam int RAD_W      = 23;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 8'd1;

  // Register reset values.
  localparam logic [THR_W-1:0] THR_RESET = 27'd10000;
  localparam logic [RAD_W-1:0] RAD_RESET = 23'd6371000;

  // Pi in Q60 and degree conversion constants (1e-7 degree units).
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_TURN_U = 64'd1800000000;
  localparam logic [63:0] DEG_Q64     = PI_Q60 / HALF_TURN_U;
  localparam logic [63:0] DEG_RM64    = PI_Q60 % HALF_TURN_U;
  localparam logic [31:0] DEG_Q       = DEG_Q64[31:0];
  localparam logic [31:0] DEG_RM      = DEG_RM64[31:0];
  localparam logic [63:0] DEG_HALF    = 64'd900000000;

  // Reciprocal of a half turn, ceil(2^92 / 1.8e9). Multiplying a dividend
  // below 2^61 by it and keeping bits 92 and up gives the exact floor quotient.
  localparam logic [95:0] DEG_RECIP96 =
    ((96'd1 << 92) + 96'd1799999999) / 96'd1800000000;
  localparam logic [63:0] DEG_RECIP = DEG_RECIP96[63:0];

  localparam logic signed [33:0] FULL_TURN    = 34'sd3600000000;
  localparam logic signed [33:0] HALF_TURN    = 34'sd1800000000;
  localparam logic signed [33:0] QUARTER_TURN = 34'sd900000000;

  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DL_DIFF,
    ST_DL_MOD,
    ST_DL_WRAP,
    ST_SC_FOLD,
    ST_DEG_HI,
    ST_DEG_LO,
    ST_DIV,
    ST_ROT_INIT,
    ST_CORDIC,
    ST_MUL_SET,
    ST_MUL_PP,
    ST_MUL_FIN,
    ST_SC_APPLY,
    ST_VEC_INIT,
    ST_VEC_POST,
    ST_VEC_FIX,
    ST_VEC_DONE,
    ST_DONE
  } state_t;

  // Product operations; OP_DEG is issued first, the rest in the order listed.
  typedef enum logic [3:0] {
    OP_RY,
    OP_RX,
    OP_A,
    OP_T,
    OP_U,
    OP_U2,
    OP_V,
    OP_W,
    OP_W2,
    OP_M,
    OP_SEG,
    OP_DEG
  } op_t;

  // Arctangent of 2^-idx in Q60, from a Q62 power series.
  function automatic logic signed [63:0] atan_q60(input int idx);
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int e;
    int k;
    sum = 64'sd0;
    if (idx == 0) begin
      return $signed((PI_Q60 + 64'd2) >> 2);
    end
    for (k = 0; k < 64; k++) begin
      e = idx * (2 * k + 1);
      if (e <= 62) begin
        term = (64'sd1 <<< (62 - e)) / 64'(2 * k + 1);
        sum = (k % 2 == 1) ? sum - term : sum + term;
      end
    end
    return (sum + 64'sd2) >>> 2;
  endfunction

  // Inverse CORDIC gain in Q62 for a given iteration count.
  function automatic logic signed [63:0] inv_gain_q62(input int n);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] nx;
    logic signed [63:0] ny;
    logic [63:0] r;
    logic [63:0] q;
    int i;
    x = 64'sd1 <<< 61;
    y = 64'sd0;
    for (i = 0; i < n; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
      end
      x = nx;
      y = ny;
    end
    r = 64'd1 << 61;
    q = 64'd0;
    for (i = 0; i < 62; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= $unsigned(x)) begin
        r = r - $unsigned(x);
        q = q | 64'd1;
      end
    end
    return $signed(q);
  endfunction

endpackage

>>> rtl/gda_in_if.sv
// ----------------------------------------------------------------------------
// GPS fix input channel
// One beat carries one fix as signed latitude and longitude.
// ----------------------------------------------------------------------------
interface gda_in_if;
  import gda_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] latitude;
  logic signed [LON_W-1:0] longitude;

  modport source (output valid, latitude, longitude, input ready);
  modport sink   (input valid, latitude, longitude, output ready);
endinterface

>>> rtl/gda_out_if.sv
// ----------------------------------------------------------------------------
// Distance result channel
// One beat carries the segment, the running total and two status flags.
// ----------------------------------------------------------------------------
interface gda_out_if;
  import gda_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] segment_cm;
  logic [TOT_W-1:0] total_cm;
  logic             accepted;
  logic             first_fix;

  modport source (output valid, segment_cm, total_cm, accepted, first_fix, input ready);
  modport sink   (input valid, segment_cm, total_cm, accepted, first_fix, output ready);
endinterface

>>> rtl/gda_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// One beat writes one register, selected by index.
// ----------------------------------------------------------------------------
interface gda_cfg_if;
  import gda_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/gps_distance_accumulator_unit.sv
// Flow: one fix at a time; the input is open only while idle, and the commit
//   waits while an earlier result still stalls in the output register.
// Sharing: the shared CORDIC, divider and 32x32 multiplier carry three
//   sine/cosine evaluations, eighteen products and two vectorings per fix.
// Reset: synchronous, active low; clears the anchor, the total, the registers
//   to their defaults and the output valid.
// ----------------------------------------------------------------------------
// GPS distance accumulator
// Great-circle odometer: haversine-equivalent distance from an anchor fix,
// thresholded and summed into a saturating total, by a sequenced datapath.
// ----------------------------------------------------------------------------
module gps_distance_accumulator_unit #(
  parameter int CORDIC_ITERATIONS = gda_pkg::CORDIC_ITER_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gda_in_if.sink    in_ch,
  gda_out_if.source out_ch,
  gda_cfg_if.sink   cfg_ch
);
  import gda_pkg::*;

  localparam int IT_W = $clog2(CORDIC_ITERATIONS);
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(CORDIC_ITERATIONS - 1);
  localparam logic signed [63:0] INV_GAIN = inv_gain_q62(CORDIC_ITERATIONS);
  localparam logic signed [63:0] ROT_X0 = (INV_GAIN + 64'sd1) >>> 1;
  localparam logic signed [63:0] PI_S = $signed(PI_Q60);

  // Arctangent table.
  logic signed [63:0] atan_tab [CORDIC_ITERATIONS];
  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_atan
    localparam logic signed [63:0] ATAN_V = atan_q60(g);
    assign atan_tab[g] = ATAN_V;
  end

  // Control registers.
  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [1:0]         sc_idx_r, sc_idx_nxt;
  logic               vec_sel_r, vec_sel_nxt;
  logic               rot_r, rot_nxt;
  logic               neg_r, neg_nxt;
  logic               first_r, first_nxt;
  logic               anc_set_r, anc_set_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [THR_W-1:0]   thr_r, thr_nxt;
  logic [RAD_W-1:0]   rad_r, rad_nxt;
  logic [6:0]         dcnt_r, dcnt_nxt;
  logic [IT_W-1:0]    it_r, it_nxt;
  logic [1:0]         pp_r, pp_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [LAT_W-1:0] anc_lat_r, anc_lat_nxt;
  logic signed [LON_W-1:0] anc_lon_r, anc_lon_nxt;

  // Datapath registers.
  logic signed [LAT_W-1:0] lat_r, lat_nxt;
  logic signed [LON_W-1:0] lon_r, lon_nxt;
  logic signed [33:0] dl_r, dl_nxt;
  logic signed [30:0] tf_r, tf_nxt;
  logic [63:0]        vhi_r, vhi_nxt;
  logic [63:0]        dr_r, dr_nxt, dq_r, dq_nxt, dn_r, dn_nxt, dden_r, dden_nxt;
  logic signed [63:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [63:0]        ma_r, ma_nxt, mb_r, mb_nxt;
  logic               mneg_r, mneg_nxt;
  logic [127:0]       acc_r, acc_nxt;
  logic signed [63:0] s1_r, s1_nxt, c1_r, c1_nxt, s2_r, s2_nxt, c2_r, c2_nxt;
  logic signed [63:0] sl_r, sl_nxt, cl_r, cl_nxt;
  logic signed [63:0] tmp1_r, tmp1_nxt, tmp2_r, tmp2_nxt;
  logic signed [63:0] a_r, a_nxt, b_r, b_nxt, d_r, d_nxt, m_r, m_nxt, ang_r, ang_nxt;
  logic [SEG_W-1:0]   seg_r, seg_nxt;
  logic [SEG_W-1:0]   out_seg_r, out_seg_nxt;
  logic [TOT_W-1:0]   out_tot_r, out_tot_nxt;
  logic               out_acc_r, out_acc_nxt;
  logic               out_first_r, out_first_nxt;

  // Shared datapath signals.
  logic signed [33:0] t_sel;
  logic [30:0]        tf_abs;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic signed [63:0] xs, ys, at;
  logic               dir;
  logic [63:0]        dv_sh, dv_sub;
  logic               dv_ge;
  logic signed [63:0] opa, opb;
  logic [127:0]       rnd;
  logic [63:0]        r64;
  logic signed [63:0] mres;
  logic signed [63:0] vx, vy;
  logic [63:0]        uy;
  logic signed [63:0] nx, ny, ang_c, v_sum;
  logic [48:0]        tot_sum;
  logic               seg_acc;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.segment_cm = out_seg_r;
  assign out_ch.total_cm   = out_tot_r;
  assign out_ch.accepted   = out_acc_r;
  assign out_ch.first_fix  = out_first_r;

  // Angle selected for the next sine/cosine evaluation.
  always_comb begin
    case (sc_idx_r)
      2'd0:    t_sel = 34'(anc_lat_r);
      2'd1:    t_sel = 34'(lat_r);
      default: t_sel = dl_r;
    endcase
  end

  assign tf_abs = tf_r[30] ? 31'(-tf_r) : 31'(tf_r);

  // Shared 32x32 multiplier.
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_r)
      ST_DEG_HI: begin
        mul_a = {2'b00, tf_abs[29:0]};
        mul_b = DEG_Q;
      end
      ST_DEG_LO: begin
        mul_a = {2'b00, tf_abs[29:0]};
        mul_b = DEG_RM;
      end
      ST_MUL_PP: begin
        mul_a = pp_r[1] ? ma_r[63:32] : ma_r[31:0];
        mul_b = pp_r[0] ? mb_r[63:32] : mb_r[31:0];
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Shared CORDIC shift-add step.
  assign xs  = cx_r >>> it_r;
  assign ys  = cy_r >>> it_r;
  assign at  = atan_tab[it_r];
  assign dir = rot_r ? (cz_r >= 0) : (cy_r < 0);

  // Shared restoring divider step.
  assign dv_sh  = {dr_r[62:0], dn_r[63]};
  assign dv_ge  = (dv_sh >= dden_r);
  assign dv_sub = dv_ge ? dv_sh - dden_r : dv_sh;

  // Product operands.
  always_comb begin
    case (op_r)
      OP_RY:   begin opa = cy_r;   opb = cz_r;  end
      OP_RX:   begin opa = cx_r;   opb = cz_r;  end
      OP_A:    begin opa = c2_r;   opb = sl_r;  end
      OP_T:    begin opa = c1_r;   opb = s2_r;  end
      OP_U:    begin opa = s1_r;   opb = c2_r;  end
      OP_U2:   begin opa = tmp2_r; opb = cl_r;  end
      OP_V:    begin opa = s1_r;   opb = s2_r;  end
      OP_W:    begin opa = c1_r;   opb = c2_r;  end
      OP_W2:   begin opa = tmp2_r; opb = cl_r;  end
      OP_M:    begin opa = cx_r;   opb = INV_GAIN; end
      OP_SEG:  begin opa = ang_r;  opb = $signed(64'(rad_r) * 64'd100); end
      OP_DEG:  begin opa = $signed(dn_r); opb = $signed(DEG_RECIP); end
      default: begin opa = 64'sd0; opb = 64'sd0; end
    endcase
  end

  // Rounded product scaling; the half-turn quotient floors instead.
  always_comb begin
    case (op_r)
      OP_RY, OP_RX, OP_SEG: begin
        rnd = acc_r + (128'd1 << 59);
        r64 = rnd[123:60];
      end
      OP_M: begin
        rnd = acc_r + (128'd1 << 61);
        r64 = rnd[125:62];
      end
      OP_DEG: begin
        rnd = acc_r;
        r64 = {28'd0, acc_r[127:92]};
      end
      default: begin
        rnd = acc_r + (128'd1 << 60);
        r64 = rnd[124:61];
      end
    endcase
    mres = mneg_r ? -$signed(r64) : $signed(r64);
  end

  // Vectoring inputs.
  always_comb begin
    if (!vec_sel_r) begin
      vx = a_r[63] ? -a_r : a_r;
      vy = b_r[63] ? -b_r : b_r;
    end else begin
      vx = d_r[63] ? -d_r : d_r;
      vy = m_r;
    end
  end

  assign uy      = cy_r[63] ? 64'(-cy_r) : 64'(cy_r);
  assign nx      = cx_r - tmp1_r;
  assign ny      = cy_r + tmp2_r;
  assign ang_c   = d_r[63] ? PI_S - cz_r : cz_r;
  assign v_sum   = $signed(vhi_r + dq_r);
  assign tot_sum = {1'b0, total_r} + 49'(seg_r);
  assign seg_acc = (seg_r > {5'b00000, thr_r});

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt = state_r;   op_nxt = op_r;         sc_idx_nxt = sc_idx_r;
    vec_sel_nxt = vec_sel_r; rot_nxt = rot_r;
    neg_nxt = neg_r;       first_nxt = first_r;   anc_set_nxt = anc_set_r;
    total_nxt = total_r;   thr_nxt = thr_r;       rad_nxt = rad_r;
    dcnt_nxt = dcnt_r;     it_nxt = it_r;         pp_nxt = pp_r;
    anc_lat_nxt = anc_lat_r; anc_lon_nxt = anc_lon_r;
    lat_nxt = lat_r;       lon_nxt = lon_r;       dl_nxt = dl_r;
    tf_nxt = tf_r;         vhi_nxt = vhi_r;
    dr_nxt = dr_r;         dq_nxt = dq_r;         dn_nxt = dn_r;   dden_nxt = dden_r;
    cx_nxt = cx_r;         cy_nxt = cy_r;         cz_nxt = cz_r;
    ma_nxt = ma_r;         mb_nxt = mb_r;         mneg_nxt = mneg_r; acc_nxt = acc_r;
    s1_nxt = s1_r;         c1_nxt = c1_r;         s2_nxt = s2_r;   c2_nxt = c2_r;
    sl_nxt = sl_r;         cl_nxt = cl_r;         tmp1_nxt = tmp1_r; tmp2_nxt = tmp2_r;
    a_nxt = a_r;           b_nxt = b_r;           d_nxt = d_r;     m_nxt = m_r;
    ang_nxt = ang_r;       seg_nxt = seg_r;
    out_seg_nxt = out_seg_r; out_tot_nxt = out_tot_r;
    out_acc_nxt = out_acc_r; out_first_nxt = out_first_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    // Register writes should arrive only while the block is idle; the block itself does not enforce this.
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_THRESHOLD: thr_nxt = cfg_ch.data[THR_W-1:0];
        REG_RADIUS:    rad_nxt = cfg_ch.data[RAD_W-1:0];
        default:       ;
      endcase
    end

    unique case (state_r)
      // Take a fix; the first one after reset becomes the anchor.
      ST_IDLE: begin
        if (in_ch.valid) begin
          lat_nxt = in_ch.latitude;
          lon_nxt = in_ch.longitude;
          first_nxt = !anc_set_r;
          if (!anc_set_r) begin
            anc_lat_nxt = in_ch.latitude;
            anc_lon_nxt = in_ch.longitude;
            anc_set_nxt = 1'b1;
          end
          state_nxt = ST_DL_DIFF;
        end
      end
      // Longitude difference, reduced into (-180, 180] degrees.
      ST_DL_DIFF: begin
        dl_nxt = 34'(lon_r) - 34'(anc_lon_r);
        state_nxt = ST_DL_MOD;
      end
      ST_DL_MOD: begin
        if (dl_r >= FULL_TURN) begin
          dl_nxt = dl_r - FULL_TURN;
        end else if (dl_r <= -FULL_TURN) begin
          dl_nxt = dl_r + FULL_TURN;
        end
        state_nxt = ST_DL_WRAP;
      end
      ST_DL_WRAP: begin
        if (dl_r > HALF_TURN) begin
          dl_nxt = dl_r - FULL_TURN;
        end else if (dl_r <= -HALF_TURN) begin
          dl_nxt = dl_r + FULL_TURN;
        end
        sc_idx_nxt = 2'd0;
        state_nxt = ST_SC_FOLD;
      end
      // Fold the angle into +-90 degrees, remembering a sign flip.
      ST_SC_FOLD: begin
        if (t_sel > QUARTER_TURN) begin
          tf_nxt = 31'(t_sel - HALF_TURN);
          neg_nxt = 1'b1;
        end else if (t_sel < -QUARTER_TURN) begin
          tf_nxt = 31'(t_sel + HALF_TURN);
          neg_nxt = 1'b1;
        end else begin
          tf_nxt = 31'(t_sel);
          neg_nxt = 1'b0;
        end
        state_nxt = ST_DEG_HI;
      end
      // Degrees to radians: integer part of the scale, then the remainder,
      // whose quotient by a half turn comes from a reciprocal product.
      ST_DEG_HI: begin
        vhi_nxt = mul_p;
        state_nxt = ST_DEG_LO;
      end
      ST_DEG_LO: begin
        dn_nxt = mul_p + DEG_HALF;
        op_nxt = OP_DEG;
        state_nxt = ST_MUL_SET;
      end
      // One quotient bit per cycle.
      ST_DIV: begin
        dr_nxt = dv_sub;
        dq_nxt = {dq_r[62:0], dv_ge};
        dn_nxt = {dn_r[62:0], 1'b0};
        dcnt_nxt = dcnt_r - 7'd1;
        if (dcnt_r == 7'd1) begin
          state_nxt = ST_VEC_FIX;
        end
      end
      ST_ROT_INIT: begin
        cz_nxt = tf_r[30] ? -v_sum : v_sum;
        cx_nxt = ROT_X0;
        cy_nxt = 64'sd0;
        it_nxt = '0;
        rot_nxt = 1'b1;
        state_nxt = ST_CORDIC;
      end
      // Shared CORDIC iteration, rotation or vectoring.
      ST_CORDIC: begin
        if (dir) begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          cz_nxt = cz_r - at;
        end else begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          cz_nxt = cz_r + at;
        end
        it_nxt = it_r + 1'b1;
        if (it_r == IT_LAST) begin
          if (rot_r) begin
            op_nxt = OP_RY;
            state_nxt = ST_MUL_SET;
          end else begin
            state_nxt = ST_VEC_POST;
          end
        end
      end
      // Signed product: magnitudes, then four partial products.
      ST_MUL_SET: begin
        ma_nxt = opa[63] ? 64'(-opa) : 64'(opa);
        mb_nxt = opb[63] ? 64'(-opb) : 64'(opb);
        mneg_nxt = opa[63] ^ opb[63];
        acc_nxt = 128'd0;
        pp_nxt = 2'd0;
        state_nxt = ST_MUL_PP;
      end
      ST_MUL_PP: begin
        case (pp_r)
          2'd0:    acc_nxt = acc_r + 128'(mul_p);
          2'd3:    acc_nxt = acc_r + (128'(mul_p) << 64);
          default: acc_nxt = acc_r + (128'(mul_p) << 32);
        endcase
        pp_nxt = pp_r + 2'd1;
        if (pp_r == 2'd3) begin
          state_nxt = ST_MUL_FIN;
        end
      end
      ST_MUL_FIN: begin
        state_nxt = ST_MUL_SET;
        unique case (op_r)
          OP_DEG: begin dq_nxt = r64;    state_nxt = ST_ROT_INIT; end
          OP_RY:  begin tmp1_nxt = mres; op_nxt = OP_RX; end
          OP_RX:  begin tmp2_nxt = mres; state_nxt = ST_SC_APPLY; end
          OP_A:   begin a_nxt = mres;    op_nxt = OP_T; end
          OP_T:   begin tmp1_nxt = mres; op_nxt = OP_U; end
          OP_U:   begin tmp2_nxt = mres; op_nxt = OP_U2; end
          OP_U2:  begin b_nxt = tmp1_r - mres; op_nxt = OP_V; end
          OP_V:   begin tmp1_nxt = mres; op_nxt = OP_W; end
          OP_W:   begin tmp2_nxt = mres; op_nxt = OP_W2; end
          OP_W2: begin
            d_nxt = tmp1_r + mres;
            vec_sel_nxt = 1'b0;
            state_nxt = ST_VEC_INIT;
          end
          OP_M: begin
            m_nxt = mres;
            vec_sel_nxt = 1'b1;
            state_nxt = ST_VEC_INIT;
          end
          OP_SEG: begin
            seg_nxt = mres[SEG_W-1:0];
            state_nxt = ST_DONE;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      // First-order residual correction and quadrant sign.
      ST_SC_APPLY: begin
        case (sc_idx_r)
          2'd0: begin
            s1_nxt = neg_r ? -ny : ny;
            c1_nxt = neg_r ? -nx : nx;
          end
          2'd1: begin
            s2_nxt = neg_r ? -ny : ny;
            c2_nxt = neg_r ? -nx : nx;
          end
          default: begin
            sl_nxt = neg_r ? -ny : ny;
            cl_nxt = neg_r ? -nx : nx;
          end
        endcase
        if (sc_idx_r == 2'd2) begin
          op_nxt = OP_A;
          state_nxt = ST_MUL_SET;
        end else begin
          sc_idx_nxt = sc_idx_r + 2'd1;
          state_nxt = ST_SC_FOLD;
        end
      end
      // Vectoring; a zero vector gives zero magnitude and angle.
      ST_VEC_INIT: begin
        cx_nxt = vx;
        cy_nxt = vy;
        cz_nxt = 64'sd0;
        it_nxt = '0;
        rot_nxt = 1'b0;
        state_nxt = (vx == 64'sd0 && vy == 64'sd0) ? ST_VEC_DONE : ST_CORDIC;
      end
      ST_VEC_POST: begin
        if (cx_r > 64'sd0 && uy < 64'(cx_r)) begin
          dr_nxt = uy;
          dq_nxt = 64'd0;
          dn_nxt = 64'd0;
          dden_nxt = 64'(cx_r);
          dcnt_nxt = 7'd60;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_VEC_DONE;
        end
      end
      ST_VEC_FIX: begin
        cz_nxt = cy_r[63] ? cz_r - $signed(dq_r) : cz_r + $signed(dq_r);
        state_nxt = ST_VEC_DONE;
      end
      ST_VEC_DONE: begin
        if (!vec_sel_r) begin
          op_nxt = OP_M;
        end else begin
          ang_nxt = ang_c[63] ? 64'sd0 : ang_c;
          op_nxt = OP_SEG;
        end
        state_nxt = ST_MUL_SET;
      end
      // Commit once the output register is free.
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          if (seg_acc) begin
            total_nxt = tot_sum[48] ? TOT_MAX : tot_sum[TOT_W-1:0];
            anc_lat_nxt = lat_r;
            anc_lon_nxt = lon_r;
          end
          out_seg_nxt = seg_r;
          out_tot_nxt = seg_acc ? (tot_sum[48] ? TOT_MAX : tot_sum[TOT_W-1:0]) : total_r;
          out_acc_nxt = seg_acc;
          out_first_nxt = first_r;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r <= OP_RY;
      sc_idx_r <= 2'd0;
      vec_sel_r <= 1'b0;
      rot_r <= 1'b0;
      anc_set_r <= 1'b0;
      anc_lat_r <= '0;
      anc_lon_r <= '0;
      total_r <= '0;
      thr_r <= THR_RESET;
      rad_r <= RAD_RESET;
      dcnt_r <= 7'd0;
      it_r <= '0;
      pp_r <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      sc_idx_r <= sc_idx_nxt;
      vec_sel_r <= vec_sel_nxt;
      rot_r <= rot_nxt;
      anc_set_r <= anc_set_nxt;
      anc_lat_r <= anc_lat_nxt;
      anc_lon_r <= anc_lon_nxt;
      total_r <= total_nxt;
      thr_r <= thr_nxt;
      rad_r <= rad_nxt;
      dcnt_r <= dcnt_nxt;
      it_r <= it_nxt;
      pp_r <= pp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    first_r <= first_nxt;
    lat_r <= lat_nxt;
    lon_r <= lon_nxt;
    dl_r <= dl_nxt;
    tf_r <= tf_nxt;
    vhi_r <= vhi_nxt;
    dr_r <= dr_nxt;
    dq_r <= dq_nxt;
    dn_r <= dn_nxt;
    dden_r <= dden_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    cz_r <= cz_nxt;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
    mneg_r <= mneg_nxt;
    acc_r <= acc_nxt;
    s1_r <= s1_nxt;
    c1_r <= c1_nxt;
    s2_r <= s2_nxt;
    c2_r <= c2_nxt;
    sl_r <= sl_nxt;
    cl_r <= cl_nxt;
    tmp1_r <= tmp1_nxt;
    tmp2_r <= tmp2_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    d_r <= d_nxt;
    m_r <= m_nxt;
    ang_r <= ang_nxt;
    seg_r <= seg_nxt;
    out_seg_r <= out_seg_nxt;
    out_tot_r <= out_tot_nxt;
    out_acc_r <= out_acc_nxt;
    out_first_r <= out_first_nxt;
  end

endmodule

>>> rtl/gda_checker.sv
// ----------------------------------------------------------------------------
// GPS distance accumulator port checker
// Watches the top-level channels for handshake and result consistency.
// ----------------------------------------------------------------------------
module gda_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [gda_pkg::SEG_W-1:0] out_segment_cm,
  input logic [gda_pkg::TOT_W-1:0] out_total_cm,
  input logic                      out_accepted,
  input logic                      out_first_fix
);
  import gda_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_segment_cm) &&
      $stable(out_total_cm) && $stable(out_accepted) && $stable(out_first_fix))
    else $error("result beat changed while stalled");

  // One fix at a time: the input closes after a beat.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened right after a beat");

  // An accepted segment exceeded a nonnegative threshold.
  a_acc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_segment_cm != '0)
    else $error("accepted segment of zero length");

  // The anchoring fix starts from an empty total.
  a_first_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_fix && !out_accepted |-> out_total_cm == '0)
    else $error("first fix reported a nonzero total");

endmodule

bind gps_distance_accumulator_unit gda_checker u_gda_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_segment_cm (out_ch.segment_cm),
  .out_total_cm   (out_ch.total_cm),
  .out_accepted   (out_ch.accepted),
  .out_first_fix  (out_ch.first_fix)
);

>>> tb/sv/gps_distance_accumulator_unit_tb.sv
// ----------------------------------------------------------------------------
// GPS distance accumulator testbench
// Sends GPS fixes through the input channel. A fixed-point predictor in the
// testbench computes the great-circle segment, the running total and the
// flags for each fix the input takes. Every result beat is compared field by field
// with the oldest prediction. The run covers directed extremes, register
// sweeps and random tracks under several idle and stall mixes.
// ----------------------------------------------------------------------------
module gps_distance_accumulator_unit_tb;
  import gda_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITERS = CORDIC_ITER_DEF;
  localparam int SETTLE_CYCLES = 600;
  localparam longint HALF_DEG7 = 64'sd1800000000;
  localparam longint QUARTER_DEG7 = 64'sd900000000;
  localparam longint FULL_DEG7 = 64'sd3600000000;
  localparam logic signed [LAT_W-1:0] LAT_MAX = {1'b0, {(LAT_W-1){1'b1}}};
  localparam logic signed [LAT_W-1:0] LAT_MIN = {1'b1, {(LAT_W-1){1'b0}}};
  localparam logic signed [LON_W-1:0] LON_MAX = {1'b0, {(LON_W-1){1'b1}}};
  localparam logic signed [LON_W-1:0] LON_MIN = {1'b1, {(LON_W-1){1'b0}}};
  localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};
  localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

  typedef struct packed {
    logic [SEG_W-1:0] segment_cm;
    logic [TOT_W-1:0] total_cm;
    logic             accepted;
    logic             first_fix;
  } leg_t;

  logic clk;
  logic rst_n;

  gda_in_if  in_ch();
  gda_out_if out_ch();
  gda_cfg_if cfg_ch();

  gps_distance_accumulator_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state and configuration copies.
  longint            arctan_tab[ITERS];
  longint            gain_comp;
  logic [THR_W-1:0]  thr_cm;
  logic [RAD_W-1:0]  radius_m;
  longint            home_lat;
  longint            home_lon;
  bit                home_valid;
  longint unsigned   odometer;

  leg_t pending_legs[$];
  int   n_errors;
  int   idle_pct;
  int   stall_pct;
  longint trk_lat;
  longint trk_lon;

  // Clock.
  always #1 clk = ~clk;

  // Rounded (a * b) >> sh on unsigned 64-bit operands.
  function automatic longint unsigned mul_rnd(longint unsigned a, longint unsigned b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    return p[63:0];
  endfunction

  // Signed product rounded on the magnitude.
  function automatic longint smul_rnd(longint a, longint b, int sh);
    longint unsigned ua;
    longint unsigned ub;
    longint r;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    r = longint'(mul_rnd(ua, ub, sh));
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // floor(a * 2^bits / b) by restoring division.
  function automatic longint unsigned frac_quot(longint unsigned a, longint unsigned b, int bits);
    longint unsigned r;
    longint unsigned q;
    r = a;
    q = 0;
    for (int k = 0; k < bits; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // CORDIC vectoring with a first-order angle correction at the end.
  function automatic void vec_polar(longint x, longint y, output longint mag, output longint ang);
    longint z;
    longint nx;
    longint ny;
    longint unsigned uy;
    longint unsigned f;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    for (int i = 0; i < ITERS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += arctan_tab[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= arctan_tab[i];
      end
      x = nx;
      y = ny;
    end
    if (x > 0) begin
      uy = (y < 0) ? -y : y;
      if (uy < longint'(x)) begin
        f = frac_quot(uy, x, 60);
        z = (y >= 0) ? z + longint'(f) : z - longint'(f);
      end
    end
    mag = x;
    ang = z;
  endfunction

  // Arctangent table and gain compensation.
  function automatic void build_trig_tables();
    longint sum;
    longint term;
    longint mag;
    longint ang;
    int e;
    arctan_tab[0] = longint'((PI_Q60 + 64'd2) >> 2);
    for (int i = 1; i < ITERS; i++) begin
      sum = 0;
      for (int k = 0; ; k++) begin
        e = i * (2 * k + 1);
        if (e > 62) break;
        term = longint'((64'd1 << (62 - e)) / longint'(2 * k + 1));
        sum = (k % 2 == 1) ? sum - term : sum + term;
      end
      arctan_tab[i] = (sum + 2) >>> 2;
    end
    vec_polar(64'sd1 <<< 61, 0, mag, ang);
    gain_comp = longint'(frac_quot(64'd1 << 61, mag, 62));
  endfunction

  // 1e-7 degree to radians in Q60, rounded.
  function automatic longint deg7_rad(longint t);
    longint unsigned m;
    longint unsigned v;
    m = (t < 0) ? -t : t;
    v = m * (PI_Q60 / 64'd1800000000)
        + (m * (PI_Q60 % 64'd1800000000) + 64'd900000000) / 64'd1800000000;
    return (t < 0) ? -longint'(v) : longint'(v);
  endfunction

  // Sine and cosine in Q61 by CORDIC rotation.
  function automatic void sin_cos(longint t, output longint s, output longint c);
    bit flip;
    longint x;
    longint y;
    longint z;
    longint nx;
    longint ny;
    flip = 0;
    if (t > QUARTER_DEG7) begin
      t -= HALF_DEG7;
      flip = 1;
    end else if (t < -QUARTER_DEG7) begin
      t += HALF_DEG7;
      flip = 1;
    end
    z = deg7_rad(t);
    x = (gain_comp + 1) >>> 1;
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= arctan_tab[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += arctan_tab[i];
      end
      x = nx;
      y = ny;
    end
    nx = x - smul_rnd(y, z, 60);
    ny = y + smul_rnd(x, z, 60);
    s = flip ? -ny : ny;
    c = flip ? -nx : nx;
  endfunction

  // Great-circle distance in centimetres between two fixes.
  function automatic logic [SEG_W-1:0] arc_cm(longint lat1, longint lon1,
                                             longint lat2, longint lon2);
    longint dl;
    longint s1, c1, s2, c2, sl, cl, a, b, d, km, m, ang, unused;
    longint unsigned seg_len;
    dl = (lon2 - lon1) % FULL_DEG7;
    if (dl > HALF_DEG7) dl -= FULL_DEG7;
    else if (dl <= -HALF_DEG7) dl += FULL_DEG7;
    sin_cos(lat1, s1, c1);
    sin_cos(lat2, s2, c2);
    sin_cos(dl, sl, cl);
    a = smul_rnd(c2, sl, 61);
    b = smul_rnd(c1, s2, 61) - smul_rnd(smul_rnd(s1, c2, 61), cl, 61);
    d = smul_rnd(s1, s2, 61) + smul_rnd(smul_rnd(c1, c2, 61), cl, 61);
    vec_polar((a < 0) ? -a : a, (b < 0) ? -b : b, km, unused);
    m = smul_rnd(km, gain_comp, 62);
    if (d >= 0) begin
      vec_polar(d, m, unused, ang);
    end else begin
      vec_polar(-d, m, unused, ang);
      ang = longint'(PI_Q60) - ang;
    end
    if (ang < 0) ang = 0;
    seg_len = mul_rnd(ang, longint'(radius_m) * 100, 60);
    return seg_len[SEG_W-1:0];
  endfunction

  // Odometer update for one fix taken by the input.
  function automatic leg_t odometer_step(logic signed [LAT_W-1:0] lat,
                                         logic signed [LON_W-1:0] lon);
    leg_t r;
    r.first_fix = 0;
    if (!home_valid) begin
      home_lat = longint'(lat);
      home_lon = longint'(lon);
      home_valid = 1;
      r.first_fix = 1;
    end
    r.segment_cm = arc_cm(home_lat, home_lon, longint'(lat), longint'(lon));
    r.accepted = (r.segment_cm > thr_cm);
    if (r.accepted) begin
      odometer += r.segment_cm;
      if (odometer > TOT_MAX) odometer = TOT_MAX;
      home_lat = longint'(lat);
      home_lon = longint'(lon);
    end
    r.total_cm = odometer[TOT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Result side: random stall and field-by-field compare on each beat.
  always @(posedge clk) begin
    leg_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_legs.size() == 0) begin
          report_mismatch("unexpected result beats", 1, 0);
        end else begin
          want = pending_legs.pop_front();
          if (out_ch.segment_cm !== want.segment_cm)
            report_mismatch("segment_cm", out_ch.segment_cm, want.segment_cm);
          if (out_ch.total_cm !== want.total_cm)
            report_mismatch("total_cm", out_ch.total_cm, want.total_cm);
          if (out_ch.accepted !== want.accepted)
            report_mismatch("accepted", out_ch.accepted, want.accepted);
          if (out_ch.first_fix !== want.first_fix)
            report_mismatch("first_fix", out_ch.first_fix, want.first_fix);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Send one fix and record its prediction when the beat is taken.
  task automatic send_fix(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon);
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.latitude  <= lat;
    in_ch.longitude <= lon;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
    pending_legs.push_back(odometer_step(lat, lon));
  endtask

  // Let every result drain before touching registers.
  task automatic wait_drained();
    while (pending_legs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_THRESHOLD) thr_cm = data[THR_W-1:0];
    else if (idx == REG_RADIUS) radius_m = data[RAD_W-1:0];
  endtask

  // Register value with random junk above the register width.
  function automatic logic [CFG_DATA_W-1:0] with_junk(longint unsigned v, int w);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    return (junk & ~((32'd1 << w) - 1)) | v[CFG_DATA_W-1:0];
  endfunction

  // Anchor loading, field extremes, longitude wrap, antipodes and poles.
  task automatic test_first_fix_and_extremes();
    send_fix(0, 0);
    send_fix(0, 0);
    send_fix(100, -100);
    send_fix(2000, 3000);
    send_fix(LAT_MAX, 0);
    send_fix(LAT_MIN, 0);
    send_fix(0, LON_MAX);
    send_fix(0, LON_MIN);
    send_fix(0, 1799999999);
    send_fix(0, -1799999999);
    send_fix(0, 0);
    send_fix(0, 1800000000);
    send_fix(900000000, 0);
    send_fix(-900000000, 123456789);
    send_fix(LAT_MIN, LON_MAX);
    send_fix(LAT_MAX, LON_MIN);
  endtask

  // Register extremes, masking and writes to unused indexes.
  task automatic test_register_writes();
    wait_drained();
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(REG_RADIUS, 32'd0);
    send_fix(450000000, 900000000);
    send_fix(-450000000, -900000000);
    wait_drained();
    write_reg(REG_RADIUS, with_junk(RAD_MAX, RAD_W));
    write_reg(CFG_IDX_W'(REG_RADIUS + 1), $urandom);
    write_reg(CFG_IDX_W'($urandom_range(255, 2)), $urandom);
    send_fix(0, 0);
    send_fix(0, 1800000000);
    send_fix(1, 1800000000);
    wait_drained();
    write_reg(REG_THRESHOLD, with_junk(THR_MAX, THR_W));
    write_reg(REG_RADIUS, 32'd6000000);
    send_fix(0, 0);
    send_fix(0, 1800000000);
    wait_drained();
    write_reg(REG_THRESHOLD, 32'd100000000);
    write_reg(REG_RADIUS, 32'd7000000);
    send_fix(0, 0);
    send_fix(0, -1800000000);
  endtask

  // Random tracks: mostly small walking steps, some wild jumps.
  task automatic test_random_track(int idle, int stall, int n_items);
    longint span;
    wait_drained();
    idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < n_items; n++) begin
      if (n % 50 == 0) begin
        wait_drained();
        case ($urandom_range(3))
          0: write_reg(REG_THRESHOLD, with_junk($urandom_range(5000), THR_W));
          1: write_reg(REG_THRESHOLD, with_junk($urandom_range(200000), THR_W));
          2: write_reg(REG_THRESHOLD, $urandom);
          default: write_reg(REG_THRESHOLD, 32'd0);
        endcase
        if ($urandom_range(1)) write_reg(REG_RADIUS, $urandom_range(7000000, 6000000));
        else write_reg(REG_RADIUS, $urandom);
        if ($urandom_range(3) == 0)
          write_reg(CFG_IDX_W'($urandom_range(255, 2)), $urandom);
      end
      if ($urandom_range(4) == 0) begin
        trk_lat = longint'($signed(LAT_W'($urandom)));
        trk_lon = longint'($signed(LON_W'($urandom)));
      end else begin
        case ($urandom_range(2))
          0: span = 20;
          1: span = 2000;
          default: span = 200000;
        endcase
        trk_lat += longint'($urandom_range(2 * span)) - span;
        trk_lon += longint'($urandom_range(2 * span)) - span;
      end
      send_fix(LAT_W'(trk_lat), LON_W'(trk_lon));
    end
  endtask

  initial begin
    clk = 0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.latitude = '0;
    in_ch.longitude = '0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    n_errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    trk_lat = 0;
    trk_lon = 0;
    thr_cm = THR_RESET;
    radius_m = RAD_RESET;
    home_lat = 0;
    home_lon = 0;
    home_valid = 0;
    odometer = 0;
    build_trig_tables();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_first_fix_and_extremes();
    test_register_writes();
    test_random_track(0, 0, 250);
    test_random_track(52, 0, 250);
    test_random_track(0, 52, 250);
    test_random_track(17, 17, 250);

    while (pending_legs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
